/* design/pcgd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgd_pkg
// Shared constants and codes of the point to codebook distance engine.
// ----------------------------------------------------------------------------
package pcgd_pkg;

  // codebook depth default
  localparam int CB_DEPTH_DEFAULT = 64;

  // item kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_GRAPH = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // distance modes
  localparam logic [1:0] MODE_CART = 2'd0;
  localparam logic [1:0] MODE_AVG  = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;

  // register map (selected by paddr[2])
  localparam int         APB_AW    = 3;
  localparam logic       REG_MODE  = 1'b0;
  localparam logic       REG_COUNT = 1'b1;
  localparam logic [6:0] COUNT_RESET = 7'd64;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage : pcgd_pkg
`default_nettype wire

/* design/pcgd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgd_in_if / pcgd_out_if
// Valid/ready channels carrying load and query items in, distances out.
// ----------------------------------------------------------------------------
interface pcgd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         row_index;
  logic [5:0]         column_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [31:0]        graph_value;

  modport source(output valid, kind, row_index, column_index, coord_x, coord_y,
                 coord_z, graph_value, input ready);
  modport sink(input valid, kind, row_index, column_index, coord_x, coord_y,
               coord_z, graph_value, output ready);
endinterface

interface pcgd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  codebook_index;
  logic [31:0] distance;
  logic        last;

  modport source(output valid, codebook_index, distance, last, input ready);
  modport sink(input valid, codebook_index, distance, last, output ready);
endinterface
`default_nettype wire

/* design/pcgd_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgd_mul
// Shared registered 32x32 multiplier with the 32x33 top-bit term alongside.
// ----------------------------------------------------------------------------
module pcgd_mul import pcgd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [32:0] b_i,
  output      logic [63:0] prod_o,
  output      logic [63:0] hi_o
);

  logic [63:0] prod_q, hi_q;

  // product of low parts, plus a shifted by 32 when b has its top bit
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i[31:0]);
    hi_q   <= b_i[32] ? {a_i, 32'd0} : 64'd0;
  end

  assign prod_o = prod_q;
  assign hi_o   = hi_q;

endmodule : pcgd_mul
`default_nettype wire

/* design/pcgd_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgd_sqrt
// Truncating 64-bit integer square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module pcgd_sqrt import pcgd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output      logic        done_o,
  output      logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [36:0] trial, sub;
  logic        ge;

  // one digit step
  always_comb begin
    trial = {rem_q, rad_q[63:62]};
    sub   = {3'd0, root_q, 2'b01};
    ge    = trial >= sub;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= 35'd0;
      root_q <= 32'd0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? 35'(trial - sub) : trial[34:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule : pcgd_sqrt
`default_nettype wire

/* design/pcgd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgd_div
// Restoring divide of a 66-bit numerator by a 33-bit divisor, quotient known
// to fit 33 bits; one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pcgd_div import pcgd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [65:0] num_i,
  input  wire logic [32:0] den_i,
  output      logic        done_o,
  output      logic [32:0] quo_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q, sh_q, den_q;
  logic [33:0] trial, den_ext;
  logic        ge;

  // one quotient step
  always_comb begin
    trial   = {rem_q, sh_q[32]};
    den_ext = {1'b0, den_q};
    ge      = trial >= den_ext;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: upper numerator bits start as the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[65:33];
      sh_q  <= num_i[32:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? 33'(trial - den_ext) : trial[32:0];
      sh_q  <= {sh_q[31:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule : pcgd_div
`default_nettype wire

/* design/point_codebook_graph_distance.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_codebook_graph_distance
// Q16.16 point to codebook distance engine with graph distance modes.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_i. A point load writes one codebook entry, a
// graph load one table entry. A query item starts a distance pass over
// the n codebooks in use (register codebook_count, clamped to
// 2..CODEBOOK_DEPTH), then an output pass that sends n items on out_o in
// index order, the last one marked.
// The distance pass does three squarings per codebook on the shared
// multiplier, then uses the square root unit. The output pass reads the
// stored result in Cartesian mode, a graph path minimum in graph minimum
// mode, and two products, then the divider, in weighted average mode.
// in_i.ready is high only while no query is in work.
// A stalled receiver holds the output register; the sequencer waits for it.
// Reset clears the control state, mode to Cartesian and the count to 64;
// the codebook, graph and scratch memories are undefined until written.
// Registers: distance_mode at byte address 0, codebook_count at 4.
// ----------------------------------------------------------------------------
module point_codebook_graph_distance import pcgd_pkg::*; #(
  parameter int CODEBOOK_DEPTH = CB_DEPTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  pcgd_in_if.sink                in_i,
  pcgd_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  localparam int IW = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;
  localparam int CW = $clog2(CODEBOOK_DEPTH + 1);
  localparam int GD = CODEBOOK_DEPTH * CODEBOOK_DEPTH;
  localparam int GW = $clog2(GD);

  typedef enum logic [3:0] {
    S_IDLE, S_D_RD, S_D_SQX, S_D_SQY, S_D_SQZ, S_D_ACC, S_D_SQRT, S_D_WR,
    S_O_RD, S_O_G1, S_O_G2, S_O_M1, S_O_M2, S_O_M3, S_O_DIV, S_EMIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [1:0] mode_q;
  logic [6:0] count_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CART;
      count_q <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE:  mode_q  <= pwdata[1:0];
        REG_COUNT: count_q <= pwdata[6:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:  prdata = {30'd0, mode_q};
      REG_COUNT: prdata = {25'd0, count_q};
      default:   prdata = 32'd0;
    endcase
  end

  // clamped codebook count
  logic [CW-1:0] n_clamp;
  always_comb begin
    if (count_q > 7'(CODEBOOK_DEPTH)) n_clamp = CW'(CODEBOOK_DEPTH);
    else if (count_q < 7'd2)          n_clamp = CW'(2);
    else                              n_clamp = CW'(count_q);
  end

  // sequencer registers
  logic [CW-1:0]      k_q, n_q;
  logic [IW-1:0]      kidx;
  logic signed [31:0] qx_q, qy_q, qz_q;
  logic [IW-1:0]      first_q, second_q;
  logic [31:0]        d1_q, d2_q, dist_q, res_q;
  logic [32:0]        p1_q, p2_q;
  logic [65:0]        acc_q;
  logic               out_valid_q, out_last_q;
  logic [5:0]         out_idx_q;
  logic [31:0]        out_dist_q;

  assign kidx = k_q[IW-1:0];

  // input handshake
  logic in_fire, row_ok, col_ok;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign row_ok     = {1'b0, in_i.row_index} < 7'(CODEBOOK_DEPTH);
  assign col_ok     = {1'b0, in_i.column_index} < 7'(CODEBOOK_DEPTH);

  // codebook point memory
  logic [95:0] cb_mem [CODEBOOK_DEPTH];
  logic [95:0] cb_rd_q;
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.kind == KIND_POINT && row_ok) begin
      cb_mem[in_i.row_index[IW-1:0]] <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    end
    cb_rd_q <= cb_mem[kidx];
  end

  // graph distance memory
  logic [31:0]   gr_mem [GD];
  logic [31:0]   gr_rd_q;
  logic [GW-1:0] gr_waddr, gr_raddr;
  assign gr_waddr = GW'(in_i.row_index[IW-1:0]) * GW'(CODEBOOK_DEPTH)
                  + GW'(in_i.column_index[IW-1:0]);
  assign gr_raddr = ((state_q == S_O_G1) ? GW'(second_q) : GW'(first_q))
                  * GW'(CODEBOOK_DEPTH) + GW'(kidx);
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.kind == KIND_GRAPH && row_ok && col_ok) begin
      gr_mem[gr_waddr] <= in_i.graph_value;
    end
    gr_rd_q <= gr_mem[gr_raddr];
  end

  // scratch of euclidean distances
  logic [31:0] scr_mem [CODEBOOK_DEPTH];
  logic [31:0] scr_rd_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_D_WR) begin
      scr_mem[kidx] <= dist_q;
    end
    scr_rd_q <= scr_mem[kidx];
  end

  // coordinate difference magnitudes
  logic [32:0] dx, dy, dz;
  logic [31:0] mx, my, mz;
  always_comb begin
    dx = {qx_q[31], qx_q} - {cb_rd_q[95], cb_rd_q[95:64]};
    dy = {qy_q[31], qy_q} - {cb_rd_q[63], cb_rd_q[63:32]};
    dz = {qz_q[31], qz_q} - {cb_rd_q[31], cb_rd_q[31:0]};
    mx = dx[32] ? 32'(-dx) : dx[31:0];
    my = dy[32] ? 32'(-dy) : dy[31:0];
    mz = dz[32] ? 32'(-dz) : dz[31:0];
  end

  // shared multiplier operand select
  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [63:0] mul_prod, mul_hi;
  always_comb begin
    unique case (state_q)
      S_D_SQX: begin mul_a = mx;   mul_b = {1'b0, mx}; end
      S_D_SQY: begin mul_a = my;   mul_b = {1'b0, my}; end
      S_D_SQZ: begin mul_a = mz;   mul_b = {1'b0, mz}; end
      S_O_M1:  begin mul_a = d2_q; mul_b = p1_q;       end
      default: begin mul_a = d1_q; mul_b = p2_q;       end
    endcase
  end

  pcgd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod),
    .hi_o   (mul_hi)
  );

  // accumulator for sums of products
  logic        acc_clr;
  logic [65:0] acc_sum;
  assign acc_clr = (state_q == S_D_SQY) || (state_q == S_O_M2);
  assign acc_sum = (acc_clr ? 66'd0 : acc_q) + 66'(mul_prod) + 66'(mul_hi);

  // square root and divide units
  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [31:0] sqrt_root;
  logic [32:0] div_quo, den;
  assign sqrt_start = (state_q == S_D_ACC) && (acc_sum[65:64] == 2'd0);
  assign div_start  = (state_q == S_O_M3);
  assign den        = {1'b0, d1_q} + {1'b0, d2_q};

  pcgd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_sum[63:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  pcgd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_sum),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // path sums
  logic [32:0] path, pmin;
  assign path = {1'b0, (state_q == S_O_G1) ? d1_q : d2_q} + {1'b0, gr_rd_q};
  assign pmin = (p1_q < path) ? p1_q : path;

  logic emit_fire, k_last;
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign k_last    = (k_q + CW'(1)) == n_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      n_q         <= CW'(2);
      first_q     <= '0;
      second_q    <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !emit_fire) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && in_i.kind == KIND_QUERY) begin
            qx_q    <= in_i.coord_x;
            qy_q    <= in_i.coord_y;
            qz_q    <= in_i.coord_z;
            n_q     <= n_clamp;
            k_q     <= '0;
            state_q <= S_D_RD;
          end
        end
        S_D_RD:  state_q <= S_D_SQX;
        S_D_SQX: state_q <= S_D_SQY;
        S_D_SQY: begin acc_q <= acc_sum; state_q <= S_D_SQZ; end
        S_D_SQZ: begin acc_q <= acc_sum; state_q <= S_D_ACC; end
        S_D_ACC: begin
          // sum of squares at or above 2^64 saturates
          if (acc_sum[65:64] != 2'd0) begin
            dist_q  <= SAT32;
            state_q <= S_D_WR;
          end else begin
            state_q <= S_D_SQRT;
          end
        end
        S_D_SQRT: begin
          if (sqrt_done) begin
            dist_q  <= sqrt_root;
            state_q <= S_D_WR;
          end
        end
        S_D_WR: begin
          // two nearest, lower index wins ties
          if (k_q == '0) begin
            first_q <= kidx;
            d1_q    <= dist_q;
          end else if (dist_q < d1_q) begin
            second_q <= first_q;
            d2_q     <= d1_q;
            first_q  <= kidx;
            d1_q     <= dist_q;
          end else if (k_q == CW'(1) || dist_q < d2_q) begin
            second_q <= kidx;
            d2_q     <= dist_q;
          end
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_O_RD;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_D_RD;
          end
        end
        S_O_RD: state_q <= S_O_G1;
        S_O_G1: begin
          if (mode_q == MODE_CART) begin
            res_q   <= scr_rd_q;
            state_q <= S_EMIT;
          end else begin
            p1_q    <= path;
            state_q <= S_O_G2;
          end
        end
        S_O_G2: begin
          p2_q <= path;
          if (mode_q == MODE_AVG) begin
            if (den == 33'd0) begin
              res_q   <= p1_q[32] ? SAT32 : p1_q[31:0];
              state_q <= S_EMIT;
            end else begin
              state_q <= S_O_M1;
            end
          end else begin
            res_q   <= pmin[32] ? SAT32 : pmin[31:0];
            state_q <= S_EMIT;
          end
        end
        S_O_M1: state_q <= S_O_M2;
        S_O_M2: begin acc_q <= acc_sum; state_q <= S_O_M3; end
        S_O_M3: state_q <= S_O_DIV;
        S_O_DIV: begin
          if (div_done) begin
            res_q   <= div_quo[32] ? SAT32 : div_quo[31:0];
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= 6'(kidx);
            out_dist_q  <= res_q;
            out_last_q  <= k_last;
            k_q         <= k_q + CW'(1);
            state_q     <= k_last ? S_IDLE : S_O_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.codebook_index = out_idx_q;
  assign out_o.distance       = out_dist_q;
  assign out_o.last           = out_last_q;

  // a query item starts the distance pass at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.kind == KIND_QUERY) |=> (state_q == S_D_RD))
    else $error("query item did not start the distance pass");

  // the divider never sees a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (den != 33'd0))
    else $error("divide started with zero divisor");

  // the two nearest codebooks differ in graph modes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_O_RD && mode_q != MODE_CART) |-> (first_q != second_q))
    else $error("nearest and second nearest codebook coincide");

endmodule : point_codebook_graph_distance
`default_nettype wire
